/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/btas_pkg.sv */
// ----------------------------------------------------------------------------
// btas_pkg
// Types and constants shared by the block transfer address sequencer.
// ----------------------------------------------------------------------------
package btas_pkg;

	localparam int unsigned REG_COUNT = 16;
	localparam int unsigned IDX_W     = 4;
	localparam int unsigned CNT_W     = 5;

	localparam logic [IDX_W-1:0] PC_IDX    = 4'd15;
	localparam logic [CNT_W-1:0] FULL_CNT  = 5'd16;
	localparam logic [31:0]      WORD_STEP = 32'd4;

	typedef struct packed {
		logic [15:0] reg_list;
		logic [3:0]  base_reg;
		logic [31:0] base_value;
		logic        go_up;
		logic        pre_index;
		logic        write_back;
		logic        user_bit;
		logic        is_load;
	} req_t;

	typedef struct packed {
		logic [3:0]  reg_index;
		logic [31:0] address;
		logic        load_beat;
		logic        sequential;
		logic        base_update;
		logic [31:0] new_base;
		logic [3:0]  writeback_reg;
		logic        use_user_bank;
		logic        restore_status;
		logic        reload_pipeline;
		logic        last;
	} beat_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic beat;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic last;
	} sts_t;

endpackage

/* rtl/block_transfer_address_sequencer.sv */
// ----------------------------------------------------------------------------
// block_transfer_address_sequencer
// Expands a load/store multiple request into one address beat per register.
// ----------------------------------------------------------------------------
// One request is taken at a time. After acceptance a request passes through
// setup (block bounds and final base), then issues one beat per listed
// register, lowest register first, one per cycle while the output side keeps
// up; an empty list moves only r15. A new request is accepted in the cycle
// after the last beat is issued, even if that beat has not yet been taken.
module block_transfer_address_sequencer
	import btas_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_ready,
	input  req_t  req,
	output logic  beat_valid,
	input  logic  beat_ready,
	output beat_t beat
);

`include "assert_macros.svh"

	cmd_t cmd;
	sts_t sts;

	btas_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	btas_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cmd        (cmd),
		.sts        (sts),
		.beat_valid (beat_valid),
		.beat_ready (beat_ready),
		.beat       (beat)
	);

	`ASSERT_NXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready right after accept")
	`ASSERT_NXT(a_idle_after_last, cmd.beat && sts.last, req_ready, "not idle after last beat")
	`ASSERT_IMP(a_reload_on_last, beat_valid && beat.reload_pipeline, beat.last && beat.load_beat, "reload off last load beat")
	`ASSERT_IMP(a_restore_no_user, beat_valid && beat.restore_status, beat.reload_pipeline && !beat.use_user_bank, "restore with user bank")

endmodule

/* rtl/btas_ctrl.sv */
// ----------------------------------------------------------------------------
// btas_ctrl
// Sequencer control: accepts a request, runs setup, then issues one beat per
// listed register as the output register frees up.
// ----------------------------------------------------------------------------
module btas_ctrl
	import btas_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [1:0] {
		IDLE,
		SETUP,
		RUN
	} state_t;

	state_t state_q;

	assign req_ready = (state_q == IDLE);

	always_comb begin
		cmd       = '0;
		cmd.load  = (state_q == IDLE) && req_valid;
		cmd.setup = (state_q == SETUP);
		cmd.beat  = (state_q == RUN) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (req_valid)
						state_q <= SETUP;
				end
				SETUP: begin
					state_q <= RUN;
				end
				RUN: begin
					if (sts.out_free && sts.last)
						state_q <= IDLE;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/btas_dp.sv */
// ----------------------------------------------------------------------------
// btas_dp
// Sequencer datapath: request registers, register count, address walker,
// lowest-set-bit picker and the output beat register.
// ----------------------------------------------------------------------------
module btas_dp
	import btas_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  req_t  req,
	input  cmd_t  cmd,
	output sts_t  sts,
	output logic  beat_valid,
	input  logic  beat_ready,
	output beat_t beat
);

	logic [15:0]      list_q;
	logic [3:0]       base_reg_q;
	logic [31:0]      base_q;
	logic             up_q;
	logic             pre_q;
	logic             wb_q;
	logic             ubit_q;
	logic             load_q;
	logic [CNT_W-1:0] count_q;
	logic [31:0]      addr_q;
	logic [31:0]      final_q;
	logic             first_q;
	logic             pc_q;
	beat_t            beat_q;
	logic             beat_valid_q;

	logic [CNT_W-1:0] pop;
	logic [31:0]      span;
	logic [IDX_W-1:0] low_idx;
	logic [15:0]      remaining;
	logic [31:0]      step;
	logic             user_bank;

	always_comb begin
		pop = '0;
		for (int i = 0; i < REG_COUNT; i++)
			pop = pop + CNT_W'(req.reg_list[i]);
	end

	always_comb begin
		low_idx = '0;
		for (int i = REG_COUNT - 1; i >= 0; i--)
			if (list_q[i])
				low_idx = IDX_W'(i);
	end

	assign remaining = list_q & (list_q - 16'd1);
	assign span      = {25'd0, count_q, 2'b00};
	// downward blocks flip the pre/post sense
	assign step      = (up_q == pre_q) ? WORD_STEP : 32'd0;
	assign user_bank = ubit_q && (!pc_q || !load_q);

	assign sts.out_free = !beat_valid_q || beat_ready;
	assign sts.last     = (remaining == 16'd0);
	assign beat_valid   = beat_valid_q;
	assign beat         = beat_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (req.reg_list == 16'd0) begin
				list_q  <= 16'h8000;
				count_q <= FULL_CNT;
			end else begin
				list_q  <= req.reg_list;
				count_q <= pop;
			end
			base_reg_q <= req.base_reg;
			base_q     <= req.base_value;
			up_q       <= req.go_up;
			pre_q      <= req.pre_index;
			wb_q       <= req.write_back;
			ubit_q     <= req.user_bit;
			load_q     <= req.is_load;
		end
		if (cmd.setup) begin
			pc_q    <= list_q[PC_IDX];
			first_q <= 1'b1;
			if (up_q) begin
				addr_q  <= base_q;
				final_q <= base_q + span;
			end else begin
				addr_q  <= base_q - span;
				final_q <= base_q - span;
			end
		end
		if (cmd.beat) begin
			list_q  <= remaining;
			addr_q  <= addr_q + WORD_STEP;
			first_q <= 1'b0;

			beat_q.reg_index       <= low_idx;
			beat_q.address         <= addr_q + step;
			beat_q.load_beat       <= load_q;
			beat_q.sequential      <= !first_q;
			beat_q.base_update     <= first_q && wb_q;
			beat_q.new_base        <= final_q;
			beat_q.writeback_reg   <= base_reg_q;
			beat_q.use_user_bank   <= user_bank;
			beat_q.restore_status  <= sts.last && load_q && pc_q && ubit_q;
			beat_q.reload_pipeline <= sts.last && load_q && pc_q;
			beat_q.last            <= sts.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_valid_q <= 1'b0;
		end else if (cmd.beat) begin
			beat_valid_q <= 1'b1;
		end else if (beat_ready) begin
			beat_valid_q <= 1'b0;
		end
	end

endmodule
